### hdl/cigar_insertion_selector_top_defines.svh
// assertion macros shared by the checker of the cigar insertion selector
// depends on nothing; the including module must have clk and rst in scope
`ifndef CIGAR_INSERTION_SELECTOR_TOP_DEFINES_SVH
`define CIGAR_INSERTION_SELECTOR_TOP_DEFINES_SVH

// implication in the same cycle, off during reset
`define CIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cis implication check failed");

// implication in the next cycle, off during reset
`define CIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cis next-cycle check failed");

// next-cycle implication that also holds across reset
`define CIS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cis reset check failed");

`endif

### hdl/cis_pkg.sv
// types and constants of the cigar insertion selector
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cis_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;

  // cigar operation codes
  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } cigar_op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_START  = 3'd0,
    REG_REGION_END    = 3'd1,
    REG_TARGET_POS    = 3'd2,
    REG_EXPECTED_SIZE = 3'd3,
    REG_MIN_INS_LEN   = 3'd4
  } cfg_reg_t;

  // one qualified operation handed to the best-candidate stage
  typedef struct packed {
    logic        is_first;
    logic        is_last;
    logic        qual;
    logic [31:0] distance;
    logic [30:0] ref_pos;
    logic [30:0] query_off;
    logic [27:0] len;
  } cand_t;

endpackage

`default_nettype wire

### hdl/cis_best.sv
// best-candidate tracker and output register of the cigar insertion selector
// depends on cis_pkg (cand_t, widths)
`timescale 1ns / 1ps
`default_nettype none

module cis_best (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire cis_pkg::cand_t                 cand,
  output logic                                stall,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [cis_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tuser
);
  import cis_pkg::*;

  logic        have;
  logic [31:0] best_dist;
  logic [30:0] chosen_ref;
  logic [30:0] chosen_query;
  logic [27:0] chosen_len;

  logic have_eff;
  logic take;
  logic adv;
  logic found;
  logic [30:0] ref_sel;
  logic [30:0] query_sel;
  logic [27:0] len_sel;

  assign stall    = in_valid & cand.is_last & m_tvalid & ~m_tready;
  assign adv      = in_valid & ~stall;
  assign have_eff = have & ~cand.is_first;
  assign take     = cand.qual & (~have_eff | (cand.distance < best_dist));
  assign found    = have_eff | take;

  always_comb begin
    if (take) begin
      ref_sel   = cand.ref_pos;
      query_sel = cand.query_off;
      len_sel   = cand.len;
    end else begin
      ref_sel   = chosen_ref;
      query_sel = chosen_query;
      len_sel   = chosen_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        have <= cand.is_last ? 1'b0 : found;
      end
      if (adv && cand.is_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      best_dist    <= cand.distance;
      chosen_ref   <= cand.ref_pos;
      chosen_query <= cand.query_off;
      chosen_len   <= cand.len;
    end
    if (adv && cand.is_last) begin
      m_tuser <= found;
      if (found) begin
        m_tdata <= {6'd0, len_sel, query_sel, ref_sel};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/cigar_insertion_selector_top.sv
// cigar insertion selector: three registered stages, one cigar word per cycle
// a word with tlast passes the stage 1 and stage 2 registers before the output register raises m_tvalid
// throughput: one word per cycle; only a last word meeting a full, stalled output waits
// reset (rst, synchronous, active high) clears cursors, candidate and valids, config to defaults
// built from cis_pkg and cis_best
`timescale 1ns / 1ps
`default_nettype none

module cigar_insertion_selector_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [cis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cis_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // cigar_code [3:0], cigar_len [31:4], read_start [62:32], zero pad [63]
  input  wire logic [cis_pkg::IN_TDATA_W-1:0] s_tdata,
  // first_of_read
  input  wire logic                          s_tuser,
  // last_of_read
  input  wire logic                          s_tlast,
  // result words
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // best_ref_pos [30:0], best_query_offset [61:31], best_length [89:62], zero pad [95:90]
  output logic [cis_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // found
  output logic                               m_tuser
);
  import cis_pkg::*;

  // configuration; the ratio products are formed once at write time
  logic [30:0] region_start;
  logic [30:0] region_end;
  logic [30:0] target_pos;
  logic [32:0] exp_x3;
  logic [38:0] exp_x133;
  logic [27:0] min_ins_len;

  // walk state
  logic [31:0] ref_cursor;
  logic [31:0] query_cursor;

  // input word fields
  logic [3:0]  in_code;
  logic [27:0] in_len;
  logic [30:0] in_start;
  logic        accept;
  logic        en;
  logic        stall;

  // stage a: cursor update and length tests
  logic        cons_ref;
  logic        cons_query;
  logic [31:0] ref_base;
  logic [31:0] query_base;
  logic [32:0] ref_sum;
  logic [32:0] query_sum;
  logic [31:0] ref_adv;
  logic [31:0] ref_cursor_next;
  logic [31:0] query_cursor_next;
  logic [31:0] query_start;
  logic [29:0] len_x4;
  logic [34:0] len_x100;
  logic        ins_ok;

  // stage 1 registers
  logic        s1_valid;
  logic        s1_first;
  logic        s1_last;
  logic        s1_ins_ok;
  logic [31:0] s1_ref;
  logic [30:0] s1_qoff;
  logic [27:0] s1_len;

  // stage 1 logic: region test and distance to target
  logic [31:0] tgt_ext;
  logic        in_region;
  logic [31:0] ins_dist;

  // stage 2 registers
  logic  s2_valid;
  cand_t s2;

  assign in_code  = s_tdata[3:0];
  assign in_len   = s_tdata[31:4];
  assign in_start = s_tdata[62:32];

  // pipeline moves unless a finished read sits behind a full output
  assign en       = ~stall;
  assign s_tready = en;
  assign accept   = s_tvalid & s_tready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '1;
      target_pos   <= '0;
      exp_x3       <= 33'd3;
      exp_x133     <= 39'd133;
      min_ins_len  <= 28'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_START:  region_start <= cfg_data;
        REG_REGION_END:    region_end   <= cfg_data;
        REG_TARGET_POS:    target_pos   <= cfg_data;
        REG_EXPECTED_SIZE: begin
          exp_x3   <= {1'b0, cfg_data, 1'b0} + 33'(cfg_data);
          exp_x133 <= (39'(cfg_data) << 7) + (39'(cfg_data) << 2) + 39'(cfg_data);
        end
        REG_MIN_INS_LEN:   min_ins_len  <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // sam consume rules
  always_comb begin
    case (in_code)
      OP_M, OP_EQ, OP_X: begin
        cons_ref   = 1'b1;
        cons_query = 1'b1;
      end
      OP_I, OP_S: begin
        cons_ref   = 1'b0;
        cons_query = 1'b1;
      end
      OP_D, OP_N: begin
        cons_ref   = 1'b1;
        cons_query = 1'b0;
      end
      default: begin
        cons_ref   = 1'b0;
        cons_query = 1'b0;
      end
    endcase
  end

  // first word of a read restarts both cursors
  assign ref_base   = s_tuser ? {1'b0, in_start} : ref_cursor;
  assign query_base = s_tuser ? 32'd0 : query_cursor;

  // saturating advance
  assign ref_sum   = {1'b0, ref_base} + 33'(in_len);
  assign query_sum = {1'b0, query_base} + 33'(in_len);
  assign ref_adv   = ref_sum[32] ? '1 : ref_sum[31:0];

  assign ref_cursor_next   = cons_ref ? ref_adv : ref_base;
  assign query_cursor_next = cons_query ? (query_sum[32] ? '1 : query_sum[31:0]) : query_base;

  // insertion start: the old cursor, or all ones minus len once saturated
  assign query_start = query_sum[32] ? ~{4'd0, in_len} : query_base;

  // ratio window 0.75 .. 1.33 as exact integer compares
  assign len_x4   = {in_len, 2'b00};
  assign len_x100 = (35'(in_len) << 6) + (35'(in_len) << 5) + (35'(in_len) << 2);
  assign ins_ok   = (in_code == OP_I) && (in_len >= min_ins_len) &&
                    (33'(len_x4) >= exp_x3) && (39'(len_x100) <= exp_x133);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cursor   <= '0;
      query_cursor <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else if (en) begin
      if (accept) begin
        ref_cursor   <= ref_cursor_next;
        query_cursor <= query_cursor_next;
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_first  <= s_tuser;
      s1_last   <= s_tlast;
      s1_ins_ok <= ins_ok;
      s1_ref    <= ref_cursor_next;
      s1_qoff   <= query_start[31] ? 31'h7FFF_FFFF : query_start[30:0];
      s1_len    <= in_len;
    end
  end

  // stage 1: region test and absolute distance
  assign tgt_ext   = {1'b0, target_pos};
  assign in_region = (s1_ref >= {1'b0, region_start}) && (s1_ref <= {1'b0, region_end});
  assign ins_dist  = (s1_ref >= tgt_ext) ? (s1_ref - tgt_ext) : (tgt_ext - s1_ref);

  always_ff @(posedge clk) begin
    if (en) begin
      s2.is_first  <= s1_first;
      s2.is_last   <= s1_last;
      s2.qual      <= s1_ins_ok & in_region;
      s2.distance  <= ins_dist;
      s2.ref_pos   <= s1_ref[30:0];
      s2.query_off <= s1_qoff;
      s2.len       <= s1_len;
    end
  end

  // stage 2: keep the closest candidate, emit on the read's last word
  cis_best u_best (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .cand     (s2),
    .stall    (stall),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### hdl/cis_checker.sv
// port-level checker of the cigar insertion selector, bound to the top level
// depends on cis_pkg and cigar_insertion_selector_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "cigar_insertion_selector_top_defines.svh"

module cis_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [cis_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                        m_tuser
);
  import cis_pkg::*;

  // a stalled result holds its word
  `CIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // no candidate means all result fields read zero
  `CIS_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser, m_tdata == '0)

  // pad bits above the length stay clear
  `CIS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:90] == '0)

  // reset drops any pending result
  `CIS_ASSERT_ALWAYS(a_reset_idle, rst, !m_tvalid)

endmodule

bind cigar_insertion_selector_top cis_checker u_cis_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/cigar_insertion_selector_top_tb.sv
// self-checking bench for cigar_insertion_selector_top: directed and random cigar reads
// holds its own cursor walk and best-insertion pick, checks every result word in order
// depends on cis_pkg and the cigar_insertion_selector_top rtl
`timescale 1ns / 1ps

module cigar_insertion_selector_top_tb;
  import cis_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no word moving before giving up
  localparam int unsigned LONG_HOLD  = 400;   // one long receiver stall, in cycles
  localparam int unsigned PHASES     = 6;     // random configuration phases
  localparam int unsigned PHASE_OPS  = 275;   // least number of cigar words queued per random phase

  // one cigar word as offered on the input side
  typedef struct {
    logic [3:0]  code;
    logic [27:0] len;
    logic [30:0] start;
    logic        is_first;
    logic        is_last;
  } cigar_word_t;

  // one selection result: found flag plus the chosen insertion
  typedef struct packed {
    logic        found;
    logic [30:0] ins_rpos;
    logic [30:0] ins_qoff;
    logic [27:0] ins_len;
  } pick_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    m_tuser;

  cigar_insertion_selector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #4 clk = ~clk;

  // pending cigar words and the picks still owed by the block
  cigar_word_t op_q[$];
  pick_t       pick_q[$];

  // mirror of the configuration registers
  logic [30:0] reg_region_lo = 31'd0;
  logic [30:0] reg_region_hi = 31'h7FFFFFFF;
  logic [30:0] reg_target    = 31'd0;
  logic [30:0] reg_exp_size  = 31'd1;
  logic [27:0] reg_min_len   = 28'd30;

  // mirror of the cursor walk and the best insertion so far
  logic [31:0] rpos = '0;
  logic [31:0] qpos = '0;
  logic        have_best = 1'b0;
  logic [31:0] best_span = '0;
  logic [31:0] best_rpos = '0;
  logic [31:0] best_qpos = '0;
  logic [27:0] best_len = '0;

  int unsigned fail_count = 0;
  int unsigned picks_seen = 0;
  logic [30:0] win_base = '0;    // where reads and region sit in the current phase
  bit          tx_calm = 1'b0;   // no sender gaps while set
  bit          rx_calm = 1'b0;   // no receiver gaps while set

  // cursor add that sticks at all ones
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [27:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + 33'(b);
    return sum[32] ? 32'hFFFFFFFF : sum[31:0];
  endfunction

  // walk one accepted cigar word; a last word leaves one pick in pick_q
  function automatic void walk_cigar(cigar_word_t w);
    logic        moves_q;
    logic        moves_r;
    logic        qual;
    logic [31:0] span;
    pick_t       res;
    if (w.is_first) begin
      rpos = {1'b0, w.start};
      qpos = '0;
      have_best = 1'b0;
    end
    moves_q = 1'b0;
    moves_r = 1'b0;
    case (w.code)
      OP_M, OP_EQ, OP_X: begin
        moves_q = 1'b1;
        moves_r = 1'b1;
      end
      OP_I, OP_S: moves_q = 1'b1;
      OP_D, OP_N: moves_r = 1'b1;
      default: ;  // hard clip, pad and unknown codes move nothing
    endcase
    if (moves_r) rpos = sat_add(rpos, w.len);
    if (moves_q) qpos = sat_add(qpos, w.len);
    // ratio window 0.75 .. 1.33 done as exact integer compares
    qual = (w.code == OP_I) && (w.len >= reg_min_len) &&
           (rpos >= {1'b0, reg_region_lo}) && (rpos <= {1'b0, reg_region_hi}) &&
           ((64'(w.len) * 4) >= (64'(reg_exp_size) * 3)) &&
           ((64'(w.len) * 100) <= (64'(reg_exp_size) * 133));
    if (qual) begin
      span = (rpos >= {1'b0, reg_target}) ? rpos - {1'b0, reg_target}
                                          : {1'b0, reg_target} - rpos;
      // earlier insertion wins a tie
      if (!have_best || span < best_span) begin
        have_best = 1'b1;
        best_span = span;
        best_rpos = rpos;
        best_qpos = qpos - {4'd0, w.len};
        best_len  = w.len;
      end
    end
    if (w.is_last) begin
      res = '0;
      if (have_best) begin
        res.found    = 1'b1;
        res.ins_rpos = best_rpos[30:0];
        res.ins_qoff = (best_qpos > 32'h7FFFFFFF) ? 31'h7FFFFFFF : best_qpos[30:0];
        res.ins_len  = best_len;
      end
      pick_q.insert(pick_q.size(), res);
      have_best = 1'b0;
    end
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ------------------------------------------------------------------
  // sender: one word held in tx_cur until the block takes it
  // ------------------------------------------------------------------
  cigar_word_t tx_cur;
  bit          tx_busy = 1'b0;
  int unsigned tx_gap = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (op_q.size() != 0) begin
          tx_cur  = op_q.pop_front();
          tx_busy = 1'b1;
          tx_gap  = pick_gap(tx_calm);
        end
      end
      s_tvalid <= tx_busy;
      // word layout: code, length, read start, zero pad in the top bit
      s_tdata  <= {1'b0, tx_cur.start, tx_cur.len, tx_cur.code};
      s_tuser  <= tx_cur.is_first;
      s_tlast  <= tx_cur.is_last;
    end
  end

  // input handshake: the taken word goes straight through the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      tx_busy = 1'b0;
      walk_cigar(tx_cur);
    end
  end

  // ------------------------------------------------------------------
  // receiver: random ready gaps plus one long stall once results flow,
  // so the pipe backs up while the sender keeps offering words
  // ------------------------------------------------------------------
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;
  bit          rx_held = 1'b0;

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!rx_held && picks_seen >= 40) begin
      rx_held = 1'b1;
      rx_hold = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap(rx_calm);
    end
  end

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // output handshake: compare with the oldest owed pick
  always @(posedge clk) begin
    pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      picks_seen++;
      if (pick_q.size() == 0) begin
        $display("%0t: unexpected result word, found %0b data 0x%0h",
                 $time, m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = pick_q.pop_front();
        report_field("found", 32'(want.found), 32'(m_tuser));
        report_field("best_ref_pos", 32'(want.ins_rpos), 32'(m_tdata[30:0]));
        report_field("best_query_offset", 32'(want.ins_qoff), 32'(m_tdata[61:31]));
        report_field("best_length", 32'(want.ins_len), 32'(m_tdata[89:62]));
      end
    end
  end

  // watchdog: too long with neither side moving a word
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results owed",
                 $time, idle_cycles, pick_q.size());
        $display("cigar_insertion_selector_top regression: fail");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REGION_START:  reg_region_lo = val;
      REG_REGION_END:    reg_region_hi = val;
      REG_TARGET_POS:    reg_target    = val;
      REG_EXPECTED_SIZE: reg_exp_size  = val;
      REG_MIN_INS_LEN:   reg_min_len   = val[27:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [30:0] lo, logic [30:0] hi, logic [30:0] tgt,
                           logic [30:0] exp_size, logic [27:0] min_len);
    write_reg(REG_REGION_START, lo);
    write_reg(REG_REGION_END, hi);
    write_reg(REG_TARGET_POS, tgt);
    write_reg(REG_EXPECTED_SIZE, exp_size);
    write_reg(REG_MIN_INS_LEN, {3'd0, min_len});
  endtask

  task automatic push_op(logic [3:0] code, logic [27:0] len, logic [30:0] start,
                         bit is_first, bit is_last);
    cigar_word_t w;
    w.code     = code;
    w.len      = len;
    w.start    = start;
    w.is_first = is_first;
    w.is_last  = is_last;
    op_q.insert(op_q.size(), w);
  endtask

  // sender pauses here until every owed pick has come back, then lets the
  // pipe run dry since words without tlast leave no result to wait for
  task automatic wait_drained();
    while (op_q.size() != 0 || tx_busy || pick_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // insertion length around the called size, so the ratio edges get hit
  function automatic logic [27:0] ins_len();
    longint unsigned v;
    if (reg_exp_size > 31'd1000000 || $urandom_range(0, 9) == 0)
      return 28'($urandom_range(0, 500));
    v = (longint'(reg_exp_size) * $urandom_range(70, 140)) / 100;
    v = v + $urandom_range(0, 2);
    if (v != 0) v = v - 1;
    return 28'(v);
  endfunction

  // mostly well-formed reads near the region, some broken or noisy ones
  task automatic add_random_read();
    int unsigned n;
    int unsigned r;
    logic [3:0]  code;
    logic [27:0] len;
    logic [30:0] start;
    bit          tidy;
    n     = $urandom_range(1, 8);
    tidy  = ($urandom_range(0, 9) != 0);
    start = ($urandom_range(0, 19) == 0) ? 31'($urandom)
                                         : 31'(win_base + $urandom_range(0, 7000));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        code = OP_I;
        len  = ins_len();
      end else if (r < 95) begin
        code = 4'($urandom_range(0, 8));
        len  = 28'($urandom_range(0, 300));
      end else begin
        code = 4'($urandom_range(9, 15));
        len  = 28'($urandom);
      end
      if ($urandom_range(0, 39) == 0) len = 28'($urandom);
      push_op(code, len, start,
              tidy ? (k == 0) : ($urandom_range(0, 3) == 0),
              tidy ? (k == n - 1) : ($urandom_range(0, 2) == 0));
    end
  endtask

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin
    logic [30:0] lo;
    logic [30:0] hi;
    logic [30:0] tgt;
    logic [30:0] exp_size;
    logic [27:0] min_len;

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings: ratio window only passes length 1, below the minimum
    push_op(OP_M, 28'd10, 31'd100, 1'b1, 1'b0);
    push_op(OP_I, 28'd35, 31'd100, 1'b0, 1'b0);
    push_op(OP_H, 28'd5, 31'd100, 1'b0, 1'b1);
    wait_drained();

    // narrow region around the target, called size 40
    write_all(31'd900, 31'd1010, 31'd1000, 31'd40, 28'd30);
    // every operation at least once; equal distances keep the earlier insertion,
    // the last insertion sits past the region end
    push_op(OP_S, 28'd5, 31'd990, 1'b1, 1'b0);
    push_op(OP_M, 28'd5, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'd40, 31'd0, 1'b0, 1'b0);
    push_op(OP_D, 28'd10, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'd40, 31'd0, 1'b0, 1'b0);
    push_op(OP_N, 28'd3, 31'd0, 1'b0, 1'b0);
    push_op(OP_P, 28'd2, 31'd0, 1'b0, 1'b0);
    push_op(OP_EQ, 28'd4, 31'd0, 1'b0, 1'b0);
    push_op(OP_X, 28'd4, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'd40, 31'd0, 1'b0, 1'b0);
    push_op(OP_H, 28'd0, 31'd0, 1'b0, 1'b1);
    // unknown codes move nothing; ratio upper edge, just over it, under the minimum
    push_op(4'd9, 28'd100, 31'd998, 1'b1, 1'b0);
    push_op(4'd12, 28'd7, 31'd0, 1'b0, 1'b0);
    push_op(4'd15, 28'hFFFFFFF, 31'h7FFFFFFF, 1'b0, 1'b0);
    push_op(OP_I, 28'd53, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'd54, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'd29, 31'd0, 1'b0, 1'b0);
    push_op(OP_M, 28'd1, 31'd0, 1'b0, 1'b1);
    // no first flag right after a last word: cursors carry on
    push_op(OP_I, 28'd40, 31'd0, 1'b0, 1'b1);
    // single-word read below the region
    push_op(OP_I, 28'd40, 31'd0, 1'b1, 1'b1);
    wait_drained();

    // extremes: full region, far target, largest size and minimum;
    // query offset past 31 bits clips, then both cursors saturate
    write_all(31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h0FFFFFFF, 28'hFFFFFFF);
    push_op(OP_S, 28'hFFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b0);
    repeat (8) push_op(OP_S, 28'hFFFFFFF, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'hFFFFFFF, 31'd0, 1'b0, 1'b0);
    repeat (9) push_op(OP_M, 28'hFFFFFFF, 31'd0, 1'b0, 1'b0);
    push_op(OP_I, 28'hFFFFFFF, 31'd0, 1'b0, 1'b1);
    wait_drained();

    // zero called size: only zero-length insertions fit the window
    write_reg(REG_EXPECTED_SIZE, 31'd0);
    write_reg(REG_MIN_INS_LEN, 31'd0);
    push_op(OP_I, 28'd0, 31'd5, 1'b1, 1'b1);
    push_op(OP_M, 28'd3, 31'd7, 1'b1, 1'b0);
    push_op(OP_I, 28'd1, 31'd0, 1'b0, 1'b1);
    wait_drained();

    // random phases, each with its own window and settings
    for (int p = 0; p < PHASES; p++) begin
      win_base = 31'($urandom_range(0, 32'h7FFF0000));
      lo       = 31'(win_base + $urandom_range(0, 2000));
      hi       = 31'(lo + $urandom_range(0, 5000));
      tgt      = 31'(win_base + $urandom_range(0, 7000));
      exp_size = 31'($urandom_range(30, 400));
      min_len  = 28'($urandom_range(0, exp_size));
      // now and then a register goes to one of its limits
      if ($urandom_range(0, 5) == 0) lo = 31'd0;
      if ($urandom_range(0, 5) == 0) lo = 31'h7FFFFFFF;
      if ($urandom_range(0, 5) == 0) hi = 31'h7FFFFFFF;
      if ($urandom_range(0, 5) == 0) hi = 31'd0;
      if ($urandom_range(0, 5) == 0) tgt = ($urandom_range(0, 1) != 0) ? 31'h7FFFFFFF : 31'd0;
      if ($urandom_range(0, 7) == 0) exp_size = 31'd1;
      if ($urandom_range(0, 9) == 0) exp_size = 31'h7FFFFFFF;
      if ($urandom_range(0, 5) == 0) min_len = 28'd0;
      if ($urandom_range(0, 11) == 0) min_len = 28'hFFFFFFF;
      write_all(lo, hi, tgt, exp_size, min_len);
      // phase 1 runs both sides flat out, other phases now and then
      tx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
      rx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
      while (op_q.size() < PHASE_OPS) add_random_read();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pick_q.size() == 0) begin
      $display("cigar_insertion_selector_top regression: pass");
    end else begin
      $display("cigar_insertion_selector_top regression: fail");
    end
    $finish;
  end

endmodule
